[src/qwl_pkg.sv]
// ----------------------------------------------------------------------------
// qwl_pkg
// Shared widths, codes and types of the quarter-wave oscillator.
// ----------------------------------------------------------------------------
package qwl_pkg;

    localparam int ADDR_W   = 12;
    localparam int VALUE_W  = 15;
    localparam int SAMPLE_W = 16;
    localparam int POINTS_W = 13;
    localparam int CFG_W    = 13;

    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [VALUE_W-1:0]         t_value;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [POINTS_W-1:0]        t_points;
    typedef logic [CFG_W-1:0]           t_cfg_data;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        REG_ENABLE     = 2'd0,
        REG_SEG_START  = 2'd1,
        REG_SEG_END    = 2'd2,
        REG_SEG_POINTS = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic   write;
        logic   tick;
        logic   zero;
        logic   neg;
        t_addr  addr;
        t_value wdata;
    } t_stage;

endpackage

[src/qwl_in_if.sv]
// ----------------------------------------------------------------------------
// qwl_in_if
// Input channel: tick and table write transactions.
// ----------------------------------------------------------------------------
interface qwl_in_if;
    import qwl_pkg::*;

    logic   valid;
    logic   ready;
    t_op    op;
    t_addr  table_address;
    t_value table_value;

    modport source (output valid, output op, output table_address, output table_value,
                    input ready);
    modport sink   (input valid, input op, input table_address, input table_value,
                    output ready);
endinterface

[src/qwl_out_if.sv]
// ----------------------------------------------------------------------------
// qwl_out_if
// Output channel: one sample per tick transaction.
// ----------------------------------------------------------------------------
interface qwl_out_if;
    import qwl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[src/quarter_wave_lfo.sv]
// A tick transaction passes through registers s1, s2 and s3 (with the table read) before its sample enters the queue.
// Throughput: one transaction per cycle while ready is high, with one table RAM access per item.
// Up to eight samples may be outstanding; input ready falls only when all eight wait.
// Reset clears the phase, the configuration and the pipeline; the table is not cleared
// and holds undefined data until written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// quarter_wave_lfo
// Sine oscillator that mirrors and negates a quarter-wave table held in RAM.
// ----------------------------------------------------------------------------
module quarter_wave_lfo #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  qwl_pkg::t_reg_index    i_cfg_index,
    input  qwl_pkg::t_cfg_data     i_cfg_wdata,
    qwl_in_if.sink                 i_in,
    qwl_out_if.source              o_out
);
    import qwl_pkg::*;

    localparam int RAM_DEPTH  = (TABLE_DEPTH < (1 << ADDR_W)) ? TABLE_DEPTH : (1 << ADDR_W);
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam bit RAM_POW2   = (RAM_DEPTH == (1 << RAM_AW));
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    logic    r_enable;
    t_addr   r_start;
    t_addr   r_end;
    t_points r_points;

    t_addr      r_step;
    logic [1:0] r_quad;
    t_addr      n_step;
    logic [1:0] n_quad;

    logic   in_accept;
    logic   tick_go;
    logic   wrap;
    t_addr  idx;
    t_addr  tick_addr;
    t_stage s1_in;

    logic   r_s1_valid;
    t_stage r_s1;
    logic   r_s2_valid;
    t_stage r_s2;

    logic [RAM_AW-1:0] slot;
    logic              ram_we;
    logic              ram_re;
    t_value            ram_rdata;

    logic    r_s3_valid;
    logic    r_s3_zero;
    logic    r_s3_neg;
    t_sample mag_ext;
    t_sample push_sample;

    t_sample            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_pending;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_start  <= '0;
            r_end    <= '0;
            r_points <= POINTS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENABLE:     r_enable <= i_cfg_wdata[0];
                REG_SEG_START:  r_start  <= i_cfg_wdata[ADDR_W-1:0];
                REG_SEG_END:    r_end    <= i_cfg_wdata[ADDR_W-1:0];
                REG_SEG_POINTS: r_points <= i_cfg_wdata[POINTS_W-1:0];
                default:        r_enable <= r_enable;
            endcase
        end
    end

    assign in_accept = i_in.valid && i_in.ready;
    assign tick_go   = in_accept && (i_in.op == OP_TICK);
    assign wrap      = ({1'b0, r_step} == (r_points - POINTS_W'(1)));
    assign idx       = wrap ? '0 : r_step;
    assign n_quad    = wrap ? r_quad + 2'd1 : r_quad;
    assign n_step    = idx + ADDR_W'(1);
    assign tick_addr = n_quad[0] ? (r_end - idx) : (r_start + idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_quad <= '0;
        end else if (tick_go && r_enable) begin
            r_step <= n_step;
            r_quad <= n_quad;
        end
    end

    always_comb begin
        s1_in.write = (i_in.op == OP_WRITE);
        s1_in.tick  = (i_in.op == OP_TICK);
        s1_in.zero  = !r_enable;
        s1_in.neg   = n_quad[1];
        s1_in.addr  = (i_in.op == OP_WRITE) ? i_in.table_address : tick_addr;
        s1_in.wdata = i_in.table_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2.tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1      <= s1_in;
        r_s2      <= r_s1;
        r_s3_zero <= r_s2.zero;
        r_s3_neg  <= r_s2.neg;
    end

    generate
        if (RAM_POW2) begin : g_mask
            assign slot = r_s2.addr[RAM_AW-1:0];
        end else begin : g_recip
            // Exact quotient by reciprocal: the error stays below one for 12-bit addresses.
            localparam int      SHIFT   = 2 * ADDR_W;
            localparam longint  RECIP   = ((longint'(1) <<< SHIFT) + RAM_DEPTH - 1) / RAM_DEPTH;
            localparam int      RECIP_W = $clog2(RECIP + 1);
            localparam int      PROD_W  = ADDR_W + RECIP_W;

            logic [PROD_W-1:0] prod;
            t_addr             r_quot;
            t_addr             rem;

            assign prod = PROD_W'(r_s1.addr) * PROD_W'(RECIP);

            always_ff @(posedge i_clk) begin
                r_quot <= ADDR_W'(prod >> SHIFT);
            end

            assign rem  = r_s2.addr - ADDR_W'(r_quot * ADDR_W'(RAM_DEPTH));
            assign slot = rem[RAM_AW-1:0];
        end
    endgenerate

    assign ram_we = r_s2_valid && r_s2.write;
    assign ram_re = r_s2_valid && r_s2.tick && !r_s2.zero;

    qwl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (r_s2.wdata),
        .i_re    (ram_re),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    assign mag_ext = signed'({1'b0, ram_rdata});

    always_comb begin
        priority if (r_s3_zero) begin
            push_sample = '0;
        end else if (r_s3_neg) begin
            push_sample = -mag_ext;
        end else begin
            push_sample = mag_ext;
        end
    end

    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_fifo[r_wr_ptr] <= push_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_pending <= '0;
        end else begin
            if (r_s3_valid) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count   <= r_count + CNT_W'(r_s3_valid) - CNT_W'(pop);
            r_pending <= r_pending + CNT_W'(tick_go) - CNT_W'(pop);
        end
    end

    assign i_in.ready   = (r_pending < CNT_W'(FIFO_DEPTH));
    assign o_out.valid  = (r_count != '0);
    assign o_out.sample = r_fifo[r_rd_ptr];

`ifndef SYNTHESIS
    a_pending_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == r_count + CNT_W'(r_s1_valid & r_s1.tick)
                   + CNT_W'(r_s2_valid & r_s2.tick) + CNT_W'(r_s3_valid))
        else $error("Outstanding sample count does not match the pipeline and queue.");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> r_count < CNT_W'(FIFO_DEPTH))
        else $error("Sample pushed into a full output queue.");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enable |=> $stable(r_step) && $stable(r_quad))
        else $error("Phase moved while the oscillator was disabled.");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !r_s3_valid |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("Output queue count did not fall on a transaction.");
`endif
endmodule

[src/qwl_ram.sv]
// ----------------------------------------------------------------------------
// qwl_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module qwl_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
